FILE: hw/rtl/rpeg_pkg.sv
// Shared types, constants and elaboration-time functions of the RGB pad effect generator.
// Depends on nothing; every other file in hw/rtl imports it.
package rpeg_pkg;

    // Default sizes handed to the top level.
    localparam int GRID_SIDE_DEF  = 8;
    localparam int SINE_DEPTH_DEF = 1024;
    localparam int MAX_PADS       = 64;

    // Datapath widths.
    localparam int MW     = 34;  // shared multiplier operand width (signed)
    localparam int CW     = 20;  // Q16 intensity width (signed)
    localparam int SW     = 18;  // sine table entry width (signed Q16)
    localparam int XY_W   = 4;   // pad column and row width
    localparam int BAR_W  = 5;   // bar length width
    localparam int PAD_NW = 7;   // pad number width

    // Fixed-point constants.
    localparam logic [63:0] INV2PI_Q32  = 64'd683565276;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // Configuration register indexes.
    localparam logic [2:0] CFG_EFFECT_MODE = 3'd0;
    localparam logic [2:0] CFG_BRIGHTNESS  = 3'd1;
    localparam logic [2:0] CFG_SPEED       = 3'd2;
    localparam logic [2:0] CFG_CPU_BAR     = 3'd3;
    localparam logic [2:0] CFG_RAM_BAR     = 3'd4;
    localparam logic [2:0] CFG_CORNER      = 3'd5;

    // Effect codes; unused codes render the solid color.
    localparam logic [2:0] EFF_RAINBOW = 3'd0;
    localparam logic [2:0] EFF_BREATHE = 3'd1;
    localparam logic [2:0] EFF_WAVE    = 3'd2;
    localparam logic [2:0] EFF_STARS   = 3'd3;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE,
        ST_F_PT, ST_F_Q25, ST_F_Q25B, ST_F_U, ST_F_W1, ST_F_W2,
        ST_F_NS, ST_F_NR, ST_F_BR, ST_F_BV,
        ST_PAD,
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5,
        ST_WV0, ST_WV1, ST_WV2, ST_WV3,
        ST_SR0, ST_SR1, ST_SR2, ST_SR3,
        ST_SD0, ST_SD1, ST_SD2, ST_SD3,
        ST_OVL, ST_O1, ST_O2, ST_O3,
        ST_FIN
    } state_t;

    // Per-pad constants looked up by pad index.
    typedef struct packed {
        logic [PAD_NW-1:0] pad_number;
        logic [XY_W-1:0]   x;
        logic [XY_W-1:0]   y;
        logic [31:0]       hue_off;
        logic [31:0]       rad_turn;
        logic [31:0]       star_base;
        logic [4:0]        star_res;
    } pad_info_t;

    // Floor square root of a 64-bit value, bit by bit.
    function automatic logic [31:0] isqrt64(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bit_v;
        rem  = n;
        root = 64'd0;
        for (int i = 31; i >= 0; i--) begin
            bit_v = 64'd1 << (2 * i);
            if (rem >= root + bit_v) begin
                rem  = rem - (root + bit_v);
                root = (root >> 1) + bit_v;
            end else begin
                root = root >> 1;
            end
        end
        return root[31:0];
    endfunction

    // Sine of a Q32 turn in Q16, from an odd series in Q30 over one quadrant.
    function automatic logic signed [SW-1:0] sine_q16(input logic [63:0] t);
        logic [1:0]         quad;
        logic [63:0]        u;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        quad = t[31:30];
        u    = {34'd0, t[29:0]};
        if (quad[0])
            u = (64'd1 << 30) - u;
        x    = (u * PI_HALF_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        if (sum < 0)
            sum = 64'sd0;
        sum = (sum + 64'sd8192) >>> 14;
        return quad[1] ? -SW'(sum) : SW'(sum);
    endfunction

    // Q16 intensity to a 0..63 level, rounded and clamped.
    function automatic logic [5:0] level63(input logic signed [CW-1:0] v);
        logic signed [CW+6:0] l;
        l = ((CW+7)'(v) <<< 6) - (CW+7)'(v) + (CW+7)'(32768);
        l = l >>> 16;
        if (v <= 0)
            return 6'd0;
        else if (l > 63)
            return 6'd63;
        else
            return l[5:0];
    endfunction

endpackage

FILE: hw/rtl/rgb_pad_effect_generator_core.sv
// Top level of the RGB pad effect generator: sequencer, frame setup and pad datapath.
// Depends on rpeg_pkg, rpeg_mul, rpeg_sine_rom and rpeg_pad_table.

// Each input item is one frame tick carrying the CPU and RAM load. The block
// advances its Q16.16 phase, then emits one item per pad (up to 64, top row
// first, left to right), with tlast on the final pad. Most arithmetic runs
// through one registered 34x34 multiplier under a sequencer: a setup run per
// frame, then per pad the wave, stars, solid or HSV (rainbow and breathing)
// steps, with extra dimming steps on a CPU-bar row outside the bar. The last
// step of each pad waits while the output register is full and not taken.
// The block takes no new item until the last pad of the frame has been
// loaded into the output register. SineDepth is expected to be a power of two.
module rgb_pad_effect_generator_core #(
    parameter int GridSide  = rpeg_pkg::GRID_SIDE_DEF,
    parameter int SineDepth = rpeg_pkg::SINE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [6:0] cpu_load, [13:7] ram_load, [15:14] zero
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [6:0] pad_number, [12:7] red_level,
                                   // [18:13] green_level, [24:19] blue_level, [31:25] zero
    output logic        m_tlast
);
    import rpeg_pkg::*;

    localparam int NPADS = (GridSide * GridSide > MAX_PADS) ? MAX_PADS : GridSide * GridSide;
    localparam int IW    = $clog2(NPADS);
    localparam int AW    = $clog2(SineDepth);

    // Configuration registers.
    logic [2:0] effect_mode_reg;
    logic [6:0] brightness_reg;
    logic [5:0] speed_reg;
    logic       cpu_bar_en_reg;
    logic       ram_bar_en_reg;
    logic       corner_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_mode_reg <= 3'd0;
            brightness_reg  <= 7'd70;
            speed_reg       <= 6'd20;
            cpu_bar_en_reg  <= 1'b0;
            ram_bar_en_reg  <= 1'b0;
            corner_en_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EFFECT_MODE: effect_mode_reg <= cfg_data[2:0];
                CFG_BRIGHTNESS:  brightness_reg  <= cfg_data;
                CFG_SPEED:       speed_reg       <= cfg_data[5:0];
                CFG_CPU_BAR:     cpu_bar_en_reg  <= cfg_data[0];
                CFG_RAM_BAR:     ram_bar_en_reg  <= cfg_data[0];
                CFG_CORNER:      corner_en_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Constant tables indexed by settings, loads and small remainders.
    logic [12:0] step_tbl  [64];
    logic [16:0] bq_tbl    [128];
    logic [16:0] green_tbl [128];
    logic [BAR_W-1:0] barn_tbl [128];
    logic [16:0] hr_tbl    [32];
    logic [14:0] hb_tbl    [32];

    for (genvar i = 0; i < 64; i++)
    begin : g_step
        assign step_tbl[i] = 13'((458752 * (4 + i) + 2000) / 4000);
    end

    for (genvar i = 0; i < 128; i++)
    begin : g_load
        assign bq_tbl[i]    = 17'((i * 65536 + 50) / 100);
        assign green_tbl[i] = (i >= 100) ? 17'd0 : 17'(((100 - i) * 65536 + 50) / 100);
        assign barn_tbl[i]  = BAR_W'(i * GridSide / 100);
    end

    for (genvar i = 0; i < 32; i++)
    begin : g_frac
        assign hr_tbl[i] = 17'(i * 131072 / 25);
        assign hb_tbl[i] = 15'(i * 32768 / 25);
    end

    // State and frame registers.
    state_t state_reg, state_next;

    logic [31:0]          phase_reg;
    logic [6:0]           cpu_reg;
    logic [6:0]           ram_reg;
    logic [31:0]          pt_reg;
    logic [31:0]          pt5_reg;
    logic [27:0]          q_reg;
    logic [31:0]          hue_r_reg;
    logic [31:0]          hue_b_reg;
    logic [25:0]          u_reg;
    logic [31:0]          w1_reg;
    logic [31:0]          star_t_reg;
    logic [4:0]           star_r_reg;
    logic signed [CW-1:0] breath_v_reg;
    logic [IW-1:0]        cnt_reg;

    // Pad registers.
    logic signed [CW-1:0] c0_reg, c1_reg, c2_reg;
    logic signed [CW-1:0] pv_reg, qv_reg;
    logic [15:0]          f_reg;
    logic [2:0]           sector_reg;

    // Output register.
    logic                 ov_reg;
    logic [PAD_NW-1:0]    out_pad_reg;
    logic [5:0]           out_r_reg, out_g_reg, out_b_reg;
    logic                 out_last_reg;

    // Shared units.
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] p;
    logic signed [CW-1:0]   pq;
    logic [31:0]            rom_turn;
    logic [31+AW+1:0]       rom_prod;
    logic [AW-1:0]          rom_addr;
    logic signed [SW-1:0]   sd;
    pad_info_t              info;

    rpeg_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (p)
    );

    rpeg_sine_rom #(
        .SineDepth (SineDepth)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (sd)
    );

    rpeg_pad_table #(
        .GridSide (GridSide),
        .NumPads  (NPADS)
    ) u_tbl (
        .pad_idx (cnt_reg),
        .info    (info)
    );

    // Common derived values.
    logic [16:0]          bq;
    logic signed [CW-1:0] half_sin;
    logic [16:0]          m_val;
    logic [33:0]          p3;
    logic [27:0]          u3;
    logic [11:0]          q19;
    logic [16:0]          r19;
    logic [4:0]           r25;
    logic                 is_rainbow;
    logic                 is_hsv;
    logic signed [CW-1:0] hsv_v;
    logic [15:0]          hsv_s;
    logic [31:0]          hsv_h;
    logic [34:0]          h6;
    logic [5:0]           star_sum;
    logic                 star_hit;
    logic                 top_row;
    logic                 bottom_row;
    logic                 cpu_in_bar;
    logic                 ram_in_bar;
    logic                 out_free;
    logic                 last_pad;
    logic signed [CW-1:0] f0, f1, f2;

    assign pq         = p[16 +: CW];
    assign bq         = bq_tbl[brightness_reg];
    assign half_sin   = (CW'(65536) + CW'(sd)) >>> 1;
    assign p3         = {2'b00, phase_reg} + {1'b0, phase_reg, 1'b0};
    assign m_val      = p3[33:17];
    assign u3         = {1'b0, u_reg, 1'b0} + 28'(u_reg);
    assign q19        = p[32:21];
    assign r19        = 17'(phase_reg[31:16]) - 17'(q19) * 17'd19;
    assign r25        = 5'(phase_reg - p[31:0]);
    assign is_rainbow = (effect_mode_reg == EFF_RAINBOW);
    assign is_hsv     = is_rainbow || (effect_mode_reg == EFF_BREATHE);
    assign hsv_v      = is_rainbow ? CW'(bq) : breath_v_reg;
    assign hsv_s      = is_rainbow ? 16'd58982 : 16'd49152;
    assign hsv_h      = is_rainbow ? info.hue_off + hue_r_reg : hue_b_reg;
    assign h6         = {1'b0, hsv_h, 2'b00} + {2'b00, hsv_h, 1'b0};
    assign star_sum   = 6'(info.star_res) + 6'(star_r_reg);
    assign star_hit   = (star_sum == 6'd0) || (star_sum == 6'd19);
    assign top_row    = (info.y == XY_W'(0));
    assign bottom_row = (info.y == XY_W'(GridSide - 1));
    assign cpu_in_bar = (BAR_W'(info.x) < barn_tbl[cpu_reg]);
    assign ram_in_bar = (BAR_W'(info.x) < barn_tbl[ram_reg]);
    assign out_free   = !ov_reg || m_tready;
    assign last_pad   = (cnt_reg == IW'(NPADS - 1));

    // Sine address: breathing angle during setup, wave or star angle per pad.
    assign rom_turn = (state_reg == ST_F_NR) ? {pt_reg[30:0], 1'b0} :
                      (effect_mode_reg == EFF_WAVE) ? info.rad_turn - pt5_reg :
                      info.star_base + star_t_reg;
    assign rom_prod = (32 + AW + 1)'(rom_turn) * (32 + AW + 1)'(SineDepth);
    assign rom_addr = rom_prod[32 +: AW];

    // Final overlays applied as the pad leaves.
    always_comb
    begin
        f0 = c0_reg;
        f1 = c1_reg;
        f2 = c2_reg;
        if (ram_bar_en_reg && bottom_row && ram_in_bar)
        begin
            f0 = CW'(6554);
            f1 = CW'(green_tbl[ram_reg]);
            f2 = CW'(3277);
        end
        if (corner_en_reg && bottom_row && info.x == XY_W'(GridSide - 1))
        begin
            f0 = CW'(65536);
            f1 = CW'(6554);
            f2 = CW'(0);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_F_PT;
            ST_F_PT:   state_next = ST_F_Q25;
            ST_F_Q25:  state_next = ST_F_Q25B;
            ST_F_Q25B: state_next = ST_F_U;
            ST_F_U:    state_next = ST_F_W1;
            ST_F_W1:   state_next = ST_F_W2;
            ST_F_W2:   state_next = ST_F_NS;
            ST_F_NS:   state_next = ST_F_NR;
            ST_F_NR:   state_next = ST_F_BR;
            ST_F_BR:   state_next = ST_F_BV;
            ST_F_BV:   state_next = ST_PAD;
            ST_PAD:
            begin
                if (is_hsv)
                    state_next = ST_H0;
                else if (effect_mode_reg == EFF_WAVE)
                    state_next = ST_WV0;
                else if (effect_mode_reg == EFF_STARS)
                    state_next = ST_SR0;
                else
                    state_next = ST_SD0;
            end
            ST_H0:  state_next = ST_H1;
            ST_H1:  state_next = ST_H2;
            ST_H2:  state_next = ST_H3;
            ST_H3:  state_next = ST_H4;
            ST_H4:  state_next = ST_H5;
            ST_H5:  state_next = ST_OVL;
            ST_WV0: state_next = ST_WV1;
            ST_WV1: state_next = ST_WV2;
            ST_WV2: state_next = ST_WV3;
            ST_WV3: state_next = ST_OVL;
            ST_SR0: state_next = ST_SR1;
            ST_SR1: state_next = ST_SR2;
            ST_SR2: state_next = ST_SR3;
            ST_SR3: state_next = ST_OVL;
            ST_SD0: state_next = ST_SD1;
            ST_SD1: state_next = ST_SD2;
            ST_SD2: state_next = ST_SD3;
            ST_SD3: state_next = ST_OVL;
            ST_OVL:
            begin
                if (cpu_bar_en_reg && top_row && !cpu_in_bar)
                    state_next = ST_O1;
                else
                    state_next = ST_FIN;
            end
            ST_O1: state_next = ST_O2;
            ST_O2: state_next = ST_O3;
            ST_O3: state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                    state_next = last_pad ? ST_IDLE : ST_PAD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Multiplier operands per step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_F_PT:   begin mul_a = MW'(phase_reg);     mul_b = MW'(INV2PI_Q32);        end
            ST_F_Q25:  begin mul_a = MW'(phase_reg);     mul_b = MW'(64'd5497558139);    end
            ST_F_Q25B: begin mul_a = MW'(p[64:37]);      mul_b = MW'(25);                end
            ST_F_U:    begin mul_a = MW'(m_val);         mul_b = MW'(377);               end
            ST_F_W1:   begin mul_a = MW'(p[25:0]);       mul_b = MW'(68356527);          end
            ST_F_W2:   begin mul_a = MW'(u3);            mul_b = MW'(214748365);         end
            ST_F_NS:   begin mul_a = MW'(phase_reg[31:16]); mul_b = MW'(110377);         end
            ST_F_BR:   begin mul_a = MW'(half_sin);      mul_b = MW'(bq);                end
            ST_H0:     begin mul_a = MW'(hsv_v);         mul_b = MW'(17'(65536) - 17'(hsv_s)); end
            ST_H1:     begin mul_a = MW'(f_reg);         mul_b = MW'(hsv_s);             end
            ST_H2:     begin mul_a = MW'(hsv_v);         mul_b = MW'(CW'(65536) - pq);   end
            ST_H3:     begin mul_a = MW'(17'(65536) - 17'(f_reg)); mul_b = MW'(hsv_s);   end
            ST_H4:     begin mul_a = MW'(hsv_v);         mul_b = MW'(CW'(65536) - pq);   end
            ST_WV0:    begin mul_a = MW'(half_sin);      mul_b = MW'(bq);                end
            ST_WV1:    begin mul_a = MW'(pq);            mul_b = MW'(29491);             end
            ST_WV2:    begin mul_a = MW'(c0_reg);        mul_b = MW'(6554);              end
            ST_SR0:    begin mul_a = MW'(sd[15:0]);      mul_b = MW'(55706);             end
            ST_SR1:    begin mul_a = MW'(pq + CW'(9830)); mul_b = MW'(bq);               end
            ST_SR2:
            begin
                mul_a = MW'(pq);
                mul_b = star_hit ? MW'(16384) : MW'(1311);
            end
            ST_SD0:    begin mul_a = MW'(bq);            mul_b = MW'(32768);             end
            ST_SD1:    begin mul_a = MW'(bq);            mul_b = MW'(3277);              end
            ST_SD2:    begin mul_a = MW'(bq);            mul_b = MW'(7864);              end
            ST_OVL:    begin mul_a = MW'(c0_reg);        mul_b = MW'(9830);              end
            ST_O1:     begin mul_a = MW'(c1_reg);        mul_b = MW'(9830);              end
            ST_O2:     begin mul_a = MW'(c2_reg);        mul_b = MW'(9830);              end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 32'd0;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && s_tvalid)
            begin
                phase_reg <= phase_reg + 32'(step_tbl[speed_reg]);
                cnt_reg   <= '0;
            end
            if (state_reg == ST_FIN && out_free)
            begin
                ov_reg  <= 1'b1;
                cnt_reg <= cnt_reg + IW'(1);
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cpu_reg <= s_tdata[6:0];
                ram_reg <= s_tdata[13:7];
            end
            ST_F_Q25:  pt_reg <= p[47:16];
            ST_F_Q25B:
            begin
                q_reg   <= p[64:37];
                pt5_reg <= {pt_reg[29:0], 2'b00} + pt_reg;
            end
            ST_F_U:
            begin
                hue_r_reg <= 32'({q_reg, 17'd0}) + 32'(hr_tbl[r25]);
                hue_b_reg <= 32'({q_reg, 15'd0}) + 32'(hb_tbl[r25]);
            end
            ST_F_W1:   u_reg <= p[25:0];
            ST_F_W2:   w1_reg <= p[31:0];
            ST_F_NS:   star_t_reg <= w1_reg + 32'(p[57:30]);
            ST_F_NR:   star_r_reg <= r19[4:0];
            ST_F_BV:   breath_v_reg <= pq;
            ST_H0:
            begin
                sector_reg <= h6[34:32];
                f_reg      <= h6[31:16];
            end
            ST_H1:     pv_reg <= pq;
            ST_H3:     qv_reg <= pq;
            ST_H5:
            begin
                case (sector_reg)
                    3'd0:    begin c0_reg <= hsv_v;  c1_reg <= pq;     c2_reg <= pv_reg; end
                    3'd1:    begin c0_reg <= qv_reg; c1_reg <= hsv_v;  c2_reg <= pv_reg; end
                    3'd2:    begin c0_reg <= pv_reg; c1_reg <= hsv_v;  c2_reg <= pq;     end
                    3'd3:    begin c0_reg <= pv_reg; c1_reg <= qv_reg; c2_reg <= hsv_v;  end
                    3'd4:    begin c0_reg <= pq;     c1_reg <= pv_reg; c2_reg <= hsv_v;  end
                    default: begin c0_reg <= hsv_v;  c1_reg <= pv_reg; c2_reg <= qv_reg; end
                endcase
            end
            ST_WV1:    c0_reg <= pq;
            ST_WV2:    c1_reg <= pq;
            ST_WV3:    c2_reg <= pq;
            ST_SR2:    c0_reg <= pq;
            ST_SR3:
            begin
                if (star_hit)
                begin
                    c1_reg <= pq;
                    c2_reg <= c0_reg;
                end
                else
                begin
                    c0_reg <= pq;
                    c1_reg <= pq;
                    c2_reg <= pq;
                end
            end
            ST_SD1:    c0_reg <= pq;
            ST_SD2:    c1_reg <= pq;
            ST_SD3:    c2_reg <= pq;
            ST_OVL:
            begin
                if (cpu_bar_en_reg && top_row && cpu_in_bar)
                begin
                    c0_reg <= CW'(5243);
                    c1_reg <= CW'(green_tbl[cpu_reg]);
                    c2_reg <= CW'(3277);
                end
            end
            ST_O1:     c0_reg <= pq;
            ST_O2:     c1_reg <= pq;
            ST_O3:     c2_reg <= pq;
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_pad_reg  <= info.pad_number;
                    out_r_reg    <= level63(f0);
                    out_g_reg    <= level63(f1);
                    out_b_reg    <= level63(f2);
                    out_last_reg <= last_pad;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {7'd0, out_b_reg, out_g_reg, out_r_reg, out_pad_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: hw/rtl/rpeg_mul.sv
// Shared signed multiplier with a registered product.
// Depends on rpeg_pkg for the operand width.
module rpeg_mul (
    input  logic                             clk,
    input  logic signed [rpeg_pkg::MW-1:0]   a,
    input  logic signed [rpeg_pkg::MW-1:0]   b,
    output logic signed [2*rpeg_pkg::MW-1:0] p
);
    import rpeg_pkg::*;

    logic signed [2*MW-1:0] p_reg;

    // One product per cycle, registered before use.
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

FILE: hw/rtl/rpeg_sine_rom.sv
// Sine table over one turn in Q16 with a registered read port.
// Depends on rpeg_pkg for the entry function and widths.
module rpeg_sine_rom #(
    parameter int SineDepth = rpeg_pkg::SINE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic [$clog2(SineDepth)-1:0]   addr,
    output logic signed [rpeg_pkg::SW-1:0] data
);
    import rpeg_pkg::*;

    logic signed [SW-1:0] rom [SineDepth];
    logic signed [SW-1:0] data_reg;

    // Entries are fixed at elaboration.
    for (genvar k = 0; k < SineDepth; k++)
    begin : g_rom
        localparam logic [63:0] TurnQ32 = (64'(k) << 32) / SineDepth;
        assign rom[k] = sine_q16(TurnQ32);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

FILE: hw/rtl/rpeg_pad_table.sv
// Per-pad constants: position, pad number, hue offset, wave radius angle and star seeds.
// Depends on rpeg_pkg for pad_info_t and the square root function.
module rpeg_pad_table #(
    parameter int GridSide = rpeg_pkg::GRID_SIDE_DEF,
    parameter int NumPads  = (GridSide * GridSide > rpeg_pkg::MAX_PADS) ?
                             rpeg_pkg::MAX_PADS : GridSide * GridSide
) (
    input  logic [$clog2(NumPads)-1:0] pad_idx,
    output rpeg_pkg::pad_info_t        info
);
    import rpeg_pkg::*;

    pad_info_t tbl [NumPads];

    for (genvar p = 0; p < NumPads; p++)
    begin : g_pad
        localparam int PX = p % GridSide;
        localparam int PY = p / GridSide;
        localparam int DX = 2 * PX - (GridSide - 1);
        localparam int DY = 2 * PY - (GridSide - 1);
        localparam logic [63:0] HueOff = (64'(2 * PX + PY) << 32) / (2 * GridSide);
        localparam logic [31:0] Dist = isqrt64(64'(DX * DX + DY * DY) << 32);
        localparam logic [63:0] RadTurn = (64'(Dist) * INV2PI_Q32) >> 16;
        localparam logic [63:0] StarBase =
            ((64'(PX) * 64'd129898 + 64'(PY) * 64'd782330) * INV2PI_Q32) / 10000;
        localparam int StarRes = (PX * 17 + PY * 31) % 19;
        localparam int PadNum  = 11 + 10 * (GridSide - 1 - PY) + PX;

        assign tbl[p] = '{
            pad_number: PAD_NW'(PadNum),
            x:          XY_W'(PX),
            y:          XY_W'(PY),
            hue_off:    HueOff[31:0],
            rad_turn:   RadTurn[31:0],
            star_base:  StarBase[31:0],
            star_res:   5'(StarRes)
        };
    end

    assign info = tbl[pad_idx];

endmodule

FILE: tb/sv/tb_rgb_pad_effect_generator_core.sv
`timescale 1ns / 100ps
// Testbench for rgb_pad_effect_generator_core: frame ticks in, 64 pad colors out per tick.
// Depends on rpeg_pkg and the core; a scoreboard class predicts every pad color.

// Predicts the pad colors of each frame tick and checks them against the block.
class pad_color_board;
    int unsigned effect_mode;
    int unsigned brightness;
    int unsigned speed;
    bit          cpu_bar;
    bit          ram_bar;
    bit          corner;
    bit [31:0]   phase;
    longint      sine_tab[1024];
    // Expected items: {tlast, tdata}.
    bit [32:0]   pad_queue[$];
    int unsigned mismatches;

    function new();
        effect_mode = 0;
        brightness  = 70;
        speed       = 20;
        cpu_bar     = 0;
        ram_bar     = 0;
        corner      = 0;
        phase       = 0;
        mismatches  = 0;
        for (int k = 0; k < 1024; k++)
            sine_tab[k] = sine_series(k);
    endfunction

    // Table entry k: odd series in Q30 over one quadrant, rounded to Q16.
    function longint sine_series(int k);
        longint unsigned t, u, x, x2, term;
        longint          sum;
        int unsigned     quad;
        t    = (longint'(k) << 32) / 1024;
        quad = 32'((t >> 30) & 3);
        u    = t & 64'h3FFF_FFFF;
        if (quad & 1)
            u = (64'd1 << 30) - u;
        x    = (u * rpeg_pkg::PI_HALF_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 5; n++) begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n & 1)
                sum -= term;
            else
                sum += term;
        end
        if (sum < 0)
            sum = 0;
        sum = (sum + 8192) >>> 14;
        return (quad >= 2) ? -sum : sum;
    endfunction

    function longint sin_of(bit [31:0] a);
        return sine_tab[a[31:22]];
    endfunction

    function longint mulq(longint a, longint k);
        return (a * k) >>> 16;
    endfunction

    function longint unsigned floor_root(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function void hsv(bit [31:0] h, longint s, longint v, ref longint c[3]);
        longint unsigned h6;
        int unsigned     sector;
        longint          f, p, q, t;
        h6     = longint'(h) * 6;
        sector = 32'(h6 >> 32);
        f      = (h6 & 64'hFFFF_FFFF) >> 16;
        p      = mulq(v, 65536 - s);
        q      = mulq(v, 65536 - mulq(f, s));
        t      = mulq(v, 65536 - mulq(65536 - f, s));
        case (sector)
            0: begin c[0] = v; c[1] = t; c[2] = p; end
            1: begin c[0] = q; c[1] = v; c[2] = p; end
            2: begin c[0] = p; c[1] = v; c[2] = t; end
            3: begin c[0] = p; c[1] = q; c[2] = v; end
            4: begin c[0] = t; c[1] = p; c[2] = v; end
            default: begin c[0] = v; c[1] = p; c[2] = q; end
        endcase
    endfunction

    function bit [5:0] to_level(longint v);
        longint l;
        if (v <= 0)
            return 0;
        l = (v * 63 + 32768) >>> 16;
        return (l > 63) ? 6'd63 : l[5:0];
    endfunction

    function longint bar_green(int unsigned load);
        if (load >= 100)
            return 0;
        return ((100 - load) * 65536 + 50) / 100;
    endfunction

    function void set_reg(logic [2:0] idx, bit [6:0] val);
        case (idx)
            rpeg_pkg::CFG_EFFECT_MODE: effect_mode = val[2:0];
            rpeg_pkg::CFG_BRIGHTNESS:  brightness  = val;
            rpeg_pkg::CFG_SPEED:       speed       = val[5:0];
            rpeg_pkg::CFG_CPU_BAR:     cpu_bar     = val[0];
            rpeg_pkg::CFG_RAM_BAR:     ram_bar     = val[0];
            rpeg_pkg::CFG_CORNER:      corner      = val[0];
            default: ;
        endcase
    endfunction

    // One accepted frame tick: advance the phase and queue all 64 pads.
    function void note_tick(int unsigned cpu, int unsigned ram);
        longint          bq, breath_v, v, z, fr;
        longint          c[3];
        longint unsigned m, d, cpu_n, ram_n;
        bit [31:0]       pt, star_t, hue_r, hue_b, a, h;
        int              dx, dy;
        bit [6:0]        pad;
        bq     = (brightness * 65536 + 50) / 100;
        phase  = phase + (458752 * (4 + speed) + 2000) / 4000;
        pt     = 32'((longint'(phase) * rpeg_pkg::INV2PI_Q32) >> 16);
        hue_r  = 32'((longint'(phase) * 131072) / 25);
        hue_b  = 32'((longint'(phase) * 32768) / 25);
        a      = pt * 2;
        breath_v = mulq((65536 + sin_of(a)) / 2, bq);
        m      = (longint'(phase) * 3) >> 17;
        star_t = 32'((m * 377 * rpeg_pkg::INV2PI_Q32) / 10);
        cpu_n  = cpu * 8 / 100;
        ram_n  = ram * 8 / 100;
        for (int y = 0; y < 8; y++) begin
            for (int x = 0; x < 8; x++) begin
                case (effect_mode)
                    rpeg_pkg::EFF_RAINBOW: begin
                        h = 32'((longint'(2 * x + y) << 32) / 16);
                        hsv(h + hue_r, 58982, bq, c);
                    end
                    rpeg_pkg::EFF_BREATHE: hsv(hue_b, 49152, breath_v, c);
                    rpeg_pkg::EFF_WAVE: begin
                        dx = 2 * x - 7;
                        dy = 2 * y - 7;
                        d  = floor_root(longint'(dx * dx + dy * dy) << 32);
                        a  = 32'((d * rpeg_pkg::INV2PI_Q32) >> 16) - pt * 5;
                        v  = mulq((65536 + sin_of(a)) / 2, bq);
                        c[0] = v;
                        c[1] = mulq(v, 29491);
                        c[2] = mulq(v, 6554);
                    end
                    rpeg_pkg::EFF_STARS: begin
                        a  = 32'(((longint'(x) * 129898 + longint'(y) * 782330)
                                  * rpeg_pkg::INV2PI_Q32) / 10000) + star_t;
                        z  = sin_of(a);
                        fr = z & 64'hFFFF;
                        v  = mulq(mulq(fr, 55706) + 9830, bq);
                        if (((x * 17 + y * 31) + (phase >> 16)) % 19 == 0) begin
                            c[0] = v; c[1] = mulq(v, 16384); c[2] = v;
                        end else begin
                            c[0] = mulq(v, 1311); c[1] = c[0]; c[2] = c[0];
                        end
                    end
                    default: begin
                        c[0] = mulq(bq, 32768);
                        c[1] = mulq(bq, 3277);
                        c[2] = mulq(bq, 7864);
                    end
                endcase
                // Overlays, in order of priority from low to high.
                if (cpu_bar && y == 0) begin
                    if (x < cpu_n) begin
                        c[0] = 5243; c[1] = bar_green(cpu); c[2] = 3277;
                    end else begin
                        c[0] = mulq(c[0], 9830);
                        c[1] = mulq(c[1], 9830);
                        c[2] = mulq(c[2], 9830);
                    end
                end
                if (ram_bar && y == 7 && x < ram_n) begin
                    c[0] = 6554; c[1] = bar_green(ram); c[2] = 3277;
                end
                if (corner && x == 7 && y == 7) begin
                    c[0] = 65536; c[1] = 6554; c[2] = 0;
                end
                pad = 7'(11 + 10 * (7 - y) + x);
                pad_queue.push_back({(y == 7 && x == 7), 7'd0, to_level(c[2]),
                                     to_level(c[1]), to_level(c[0]), pad});
            end
        end
    endfunction

    // One accepted result item, compared with the oldest expected pad.
    function void check_pad(bit [31:0] data, bit last);
        bit [32:0] want;
        if (pad_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pad item: tdata=%h tlast=%b", data, last);
            return;
        end
        want = pad_queue.pop_front();
        if (want[31:0] !== data || want[32] !== last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("pad mismatch: pad exp %0d got %0d, rgb exp %0d/%0d/%0d got %0d/%0d/%0d, last exp %b got %b",
                         want[6:0], data[6:0], want[12:7], want[18:13], want[24:19],
                         data[12:7], data[18:13], data[24:19], want[32], last);
        end
    endfunction
endclass

module tb_rgb_pad_effect_generator_core;
    import rpeg_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int HOLD_START  = 30000;
    localparam int HOLD_LEN    = 3000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    pad_color_board board;
    int unsigned    cycle_count;
    int unsigned    ticks_sent;

    rgb_pad_effect_generator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock.
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Cycle counter and run limit.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("rgb_pad_effect_generator_core test failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a quiet stretch.
    initial
    begin
        int unsigned rx_cycle;
        rx_cycle = 0;
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                m_tready <= 0;
            else if (rx_cycle >= 60000 && rx_cycle < 120000)
                m_tready <= 1;
            else
                m_tready <= ($urandom_range(0, 99) >= 16);
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_pad(m_tdata, m_tlast);
    end

    // Holds the write enable for one edge; the caller drops it after the last write.
    task automatic write_reg(logic [2:0] idx, logic [6:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.set_reg(idx, val);
    endtask

    // Stops offering items, then waits until every expected pad has arrived.
    task automatic drain();
        s_tvalid <= 0;
        while (board.pad_queue.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_all(int mode, int bright, int spd, bit cb, bit rb, bit cm);
        drain();
        write_reg(CFG_EFFECT_MODE, 7'(mode));
        write_reg(CFG_BRIGHTNESS, 7'(bright));
        write_reg(CFG_SPEED, 7'(spd));
        write_reg(CFG_CPU_BAR, 7'(cb));
        write_reg(CFG_RAM_BAR, 7'(rb));
        write_reg(CFG_CORNER, 7'(cm));
        cfg_we <= 0;
    endtask

    // Offers one frame tick and holds it until accepted, then maybe idles.
    task automatic send_tick(bit [6:0] cpu, bit [6:0] ram);
        s_tdata  <= {2'b00, ram, cpu};
        s_tvalid <= 1;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_tick(32'(cpu), 32'(ram));
        ticks_sent++;
        if ((ticks_sent < 100 || ticks_sent > 160) && $urandom_range(0, 99) < 16)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 900 : 30))
                @(posedge clk);
        end
    endtask

    function automatic bit [6:0] rand_load();
        return 7'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100));
    endfunction

    initial
    begin
        int mode;
        board      = new();
        ticks_sent = 0;
        rst_n      = 0;
        cfg_we     = 0;
        cfg_index  = 0;
        cfg_data   = 0;
        s_tvalid   = 0;
        s_tdata    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // Reset settings first, then every effect with the overlays and extremes.
        send_tick(7'd0, 7'd0);
        send_tick(7'd100, 7'd100);
        for (mode = 0; mode < 8; mode++)
        begin
            write_all(mode, (mode & 1) ? 100 : 5, (mode & 1) ? 1 : 50, 1, 1, 1);
            send_tick(7'd127, 7'd12);
            send_tick(7'd37, 7'd127);
        end
        write_all(EFF_STARS, 127, 63, 1, 0, 0);
        send_tick(7'd50, 7'd99);
        write_all(EFF_WAVE, 0, 0, 0, 1, 1);
        send_tick(7'd13, 7'd88);

        // Random settings phases with random frame ticks.
        while (ticks_sent < 370)
        begin
            write_all($urandom_range(0, 7) < 6 ? $urandom_range(0, 4) : $urandom_range(5, 7),
                      $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : $urandom_range(5, 100),
                      $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(1, 50),
                      $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
            repeat ($urandom_range(5, 15))
                send_tick(rand_load(), rand_load());
        end

        drain();
        repeat (200) @(posedge clk);
        if (board.mismatches == 0 && board.pad_queue.size() == 0)
            $display("rgb_pad_effect_generator_core test passed");
        else
            $display("rgb_pad_effect_generator_core test failed");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/rpeg_pkg.sv
hw/rtl/rpeg_mul.sv
hw/rtl/rpeg_sine_rom.sv
hw/rtl/rpeg_pad_table.sv
hw/rtl/rgb_pad_effect_generator_core.sv
tb/sv/tb_rgb_pad_effect_generator_core.sv
